/* hw/rtl/jeec_pkg.sv */
// jeec_pkg: types, event and key codes shared by the envelope checker modules
// no dependencies
`timescale 1ns / 1ps

package jeec_pkg;

  localparam int CmdDepth = 4;
  localparam int CmdPtrW  = $clog2(CmdDepth);
  localparam int ResDepth = 2;
  localparam int ResPtrW  = $clog2(ResDepth);

  localparam logic [6:0]  DepthSat   = 7'd127;
  localparam logic [5:0]  MemberSat  = 6'd63;
  localparam logic [6:0]  RstMaxDepth   = 7'd64;
  localparam logic [5:0]  RstMaxMembers = 6'd16;
  localparam logic [15:0] RstMaxIdLen   = 16'd256;
  localparam logic [15:0] RstMaxSelLen  = 16'd128;

  // ascii words, byte zero in the low bits
  localparam logic [55:0] WordVersion = 56'h6E_6F69_7372_6576;
  localparam logic [15:0] WordId      = 16'h6469;
  localparam logic [31:0] WordType    = 32'h6570_7974;
  localparam logic [47:0] WordAction  = 48'h6E6F_6974_6361;
  localparam logic [55:0] WordPayload = 56'h64_616F_6C79_6170;

  typedef enum logic [2:0] {
    FN_BEGIN     = 3'd0,
    FN_SCALAR    = 3'd1,
    FN_INTEGER   = 3'd2,
    FN_STRING    = 3'd3,
    FN_START_OBJ = 3'd4,
    FN_END_OBJ   = 3'd5,
    FN_START_ARR = 3'd6,
    FN_END_ARR   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    KEY_OTHER   = 3'd0,
    KEY_VERSION = 3'd1,
    KEY_ID      = 3'd2,
    KEY_TYPE    = 3'd3,
    KEY_ACTION  = 3'd4,
    KEY_PAYLOAD = 3'd5
  } key_t;

  typedef enum logic [1:0] {
    REG_MAX_DEPTH   = 2'd0,
    REG_MAX_MEMBERS = 2'd1,
    REG_MAX_ID_LEN  = 2'd2,
    REG_MAX_SEL_LEN = 2'd3
  } reg_idx_t;

  // classified event, as queued between front and back
  typedef struct packed {
    func_t       func;
    key_t        key;
    logic [15:0] len;
    logic        has_nul;
    logic        is_one;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  max_depth;
    logic [5:0]  max_members;
    logic [15:0] max_id_len;
    logic [15:0] max_sel_len;
  } cfg_t;

  typedef struct packed {
    logic keep_going;
    logic envelope_valid;
    logic selector_taken;
  } res_t;

  // handshake between front queue and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

endpackage

/* hw/rtl/json_envelope_event_checker_unit.sv */
// json_envelope_event_checker_unit: top level, configuration registers and
// the front/back split of the envelope checker; depends on jeec_pkg, jeec_front, jeec_back
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------------
//  events  | in_func .. in_value_is_one     | transaction on in_push && !in_full
//  results | out_keep_going .. out_selector | transaction on out_pop && !out_empty
//  config  | cfg_index, cfg_wdata           | write on cfg_wr_en, no wait
//
// one event per cycle sustained while results are popped in time; an accepted event is
// written into the command queue, the back pulls it when the result queue has room and
// registers its result there, from where it is taken on an out_pop transaction
// the four-entry command queue and two-entry result queue let each side stall alone
// synchronous active-low reset clears state and loads the register defaults
`timescale 1ns / 1ps

module json_envelope_event_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_string_len,
  input  logic [63:0] in_string_head,
  input  logic        in_string_has_nul,
  input  logic        in_value_is_one,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_keep_going,
  output logic        out_envelope_valid,
  output logic        out_selector_taken,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import jeec_pkg::*;

  cfg_t      cfg_r;
  cmd_link_t link;
  logic      cmd_pop;
  res_t      res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_depth   <= RstMaxDepth;
      cfg_r.max_members <= RstMaxMembers;
      cfg_r.max_id_len  <= RstMaxIdLen;
      cfg_r.max_sel_len <= RstMaxSelLen;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_MAX_DEPTH:   cfg_r.max_depth   <= cfg_wdata[6:0];
        REG_MAX_MEMBERS: cfg_r.max_members <= cfg_wdata[5:0];
        REG_MAX_ID_LEN:  cfg_r.max_id_len  <= cfg_wdata;
        REG_MAX_SEL_LEN: cfg_r.max_sel_len <= cfg_wdata;
        default: ;
      endcase
    end
  end

  jeec_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (in_push),
    .full           (in_full),
    .func           (func_t'(in_func)),
    .string_len     (in_string_len),
    .string_head    (in_string_head),
    .string_has_nul (in_string_has_nul),
    .value_is_one   (in_value_is_one),
    .link           (link),
    .pop            (cmd_pop)
  );

  jeec_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .link    (link),
    .cmd_pop (cmd_pop),
    .empty   (out_empty),
    .pop     (out_pop),
    .res     (res)
  );

  assign out_keep_going     = res.keep_going;
  assign out_envelope_valid = res.envelope_valid;
  assign out_selector_taken = res.selector_taken;

  // a taken selector never comes with a violation
  a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_selector_taken) |-> out_keep_going)
    else $error("selector taken on a rejected transaction");

  // a complete envelope is never reported after a violation
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_envelope_valid) |-> out_keep_going)
    else $error("envelope valid while rejected");

  // result queue is empty and command queue not full straight after reset
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a full command queue drains while the result queue is empty
  a_no_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && out_empty) |=> !in_full)
    else $error("command queue stuck while result side idle");

endmodule

/* hw/rtl/jeec_front.sv */
// jeec_front: takes parse events, classifies root keys and queues the commands
// depends on jeec_pkg
`timescale 1ns / 1ps

module jeec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  jeec_pkg::func_t     func,
  input  logic [15:0]         string_len,
  input  logic [63:0]         string_head,
  input  logic                string_has_nul,
  input  logic                value_is_one,
  output jeec_pkg::cmd_link_t link,
  input  logic                pop
);
  import jeec_pkg::*;

  cmd_t               q_r [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CmdPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CmdPtrW:0]   cnt_r, cnt_nxt;
  logic               wr_en, rd_en;
  key_t               key;
  cmd_t               cmd_in;

  // bytes past the length are not looked at: each word is compared at its own length
  always_comb begin
    key = KEY_OTHER;
    case (string_len)
      16'd2: if (string_head[15:0] == WordId) key = KEY_ID;
      16'd4: if (string_head[31:0] == WordType) key = KEY_TYPE;
      16'd6: if (string_head[47:0] == WordAction) key = KEY_ACTION;
      16'd7: begin
        if (string_head[55:0] == WordVersion) key = KEY_VERSION;
        else if (string_head[55:0] == WordPayload) key = KEY_PAYLOAD;
      end
      default: key = KEY_OTHER;
    endcase
  end

  assign cmd_in = '{func: func, key: key, len: string_len,
                    has_nul: string_has_nul, is_one: value_is_one};

  assign full  = (cnt_r == (CmdPtrW+1)'(CmdDepth));
  assign wr_en = push && !full;
  assign rd_en = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + CmdPtrW'(wr_en);
    rd_ptr_nxt = rd_ptr_r + CmdPtrW'(rd_en);
    cnt_nxt    = cnt_r + (CmdPtrW+1)'(wr_en) - (CmdPtrW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wr_ptr_r] <= cmd_in;
  end

  assign link.valid = (cnt_r != '0);
  assign link.cmd   = q_r[rd_ptr_r];

endmodule

/* hw/rtl/jeec_back.sv */
// jeec_back: envelope state update per event and the result queue
// depends on jeec_pkg
`timescale 1ns / 1ps

module jeec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jeec_pkg::cfg_t      cfg,
  input  jeec_pkg::cmd_link_t link,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output jeec_pkg::res_t      res
);
  import jeec_pkg::*;

  logic [6:0] depth_r, depth_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  key_t       key_r, key_nxt;
  logic       started_r, started_nxt;
  logic       object_r, object_nxt;
  logic       completed_r, completed_nxt;
  logic       expect_r, expect_nxt;
  logic       has_sel_r, has_sel_nxt;
  logic       err_r, err_nxt;
  logic [4:0] seen_r, seen_nxt;
  logic       taken;
  logic       rv_ok;
  logic [4:0] key_bit;
  res_t       res_in;

  res_t               rq_r [ResDepth];
  logic [ResPtrW-1:0] rq_wr_r, rq_rd_r;
  logic [ResPtrW:0]   rq_cnt_r;
  logic               rq_full, fire, rq_pop;
  cmd_t               c;

  assign c       = link.cmd;
  assign rq_full = (rq_cnt_r == (ResPtrW+1)'(ResDepth));
  assign fire    = link.valid && !rq_full;
  assign cmd_pop = fire;
  assign rq_pop  = pop && (rq_cnt_r != '0);

  always_comb begin
    key_bit = 5'd0;
    case (c.key)
      KEY_VERSION: key_bit = 5'b00001;
      KEY_ID:      key_bit = 5'b00010;
      KEY_TYPE:    key_bit = 5'b00100;
      KEY_ACTION:  key_bit = 5'b01000;
      KEY_PAYLOAD: key_bit = 5'b10000;
      default:     key_bit = 5'd0;
    endcase
  end

  always_comb begin
    depth_nxt     = depth_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    started_nxt   = started_r;
    object_nxt    = object_r;
    completed_nxt = completed_r;
    expect_nxt    = expect_r;
    has_sel_nxt   = has_sel_r;
    err_nxt       = err_r;
    seen_nxt      = seen_r;
    taken         = 1'b0;
    rv_ok         = 1'b1;

    if (c.func == FN_BEGIN) begin
      depth_nxt     = '0;
      cnt_nxt       = '0;
      key_nxt       = KEY_OTHER;
      started_nxt   = 1'b0;
      object_nxt    = 1'b0;
      completed_nxt = 1'b0;
      expect_nxt    = 1'b0;
      has_sel_nxt   = 1'b0;
      err_nxt       = 1'b0;
      seen_nxt      = '0;
    end else if (!err_r) begin
      case (c.func)
        FN_SCALAR, FN_INTEGER, FN_START_OBJ, FN_START_ARR: begin
          // non-string value as a root member value
          if (depth_r == 7'd1 && !(c.func == FN_START_OBJ && depth_r == 7'd0)) begin
            if (!object_r || expect_r) begin
              err_nxt = 1'b1;
            end else begin
              if (c.func == FN_INTEGER && key_r == KEY_VERSION)
                rv_ok = c.is_one;
              else
                rv_ok = !(key_r inside {KEY_VERSION, KEY_ID, KEY_TYPE, KEY_ACTION});
              expect_nxt = 1'b1;
              key_nxt    = KEY_OTHER;
              if (!rv_ok) err_nxt = 1'b1;
            end
          end
          if (c.func == FN_START_OBJ && depth_r == 7'd0) begin
            if (started_r) err_nxt = 1'b1;
            started_nxt = 1'b1;
            object_nxt  = 1'b1;
            expect_nxt  = 1'b1;
            depth_nxt   = 7'd1;
          end else if (c.func == FN_START_OBJ || c.func == FN_START_ARR) begin
            if (c.func == FN_START_ARR && depth_r == 7'd0) begin
              started_nxt = 1'b1;
              object_nxt  = 1'b0;
              err_nxt     = 1'b1;
            end
            if (depth_r < DepthSat) depth_nxt = depth_r + 7'd1;
            if (depth_nxt > cfg.max_depth) err_nxt = 1'b1;
          end
        end
        FN_STRING: begin
          if (depth_r == 7'd1 && object_r) begin
            if (expect_r) begin
              if (cnt_r < MemberSat) cnt_nxt = cnt_r + 6'd1;
              if (cnt_nxt > cfg.max_members) err_nxt = 1'b1;
              key_nxt    = c.key;
              expect_nxt = 1'b0;
              if ((seen_r & key_bit) != '0) err_nxt = 1'b1;
              seen_nxt = seen_r | key_bit;
            end else begin
              case (key_r)
                KEY_ID:      rv_ok = (c.len <= cfg.max_id_len) && !c.has_nul;
                KEY_TYPE, KEY_ACTION: begin
                  rv_ok = (c.len != '0) && (c.len <= cfg.max_sel_len) && !c.has_nul;
                  if (rv_ok) begin
                    has_sel_nxt = 1'b1;
                    taken       = 1'b1;
                  end
                end
                KEY_VERSION: rv_ok = 1'b0;
                default:     rv_ok = 1'b1;
              endcase
              expect_nxt = 1'b1;
              key_nxt    = KEY_OTHER;
              if (!rv_ok) err_nxt = 1'b1;
            end
          end
        end
        FN_END_OBJ, FN_END_ARR: begin
          if (depth_r == 7'd0) begin
            err_nxt = 1'b1;
          end else begin
            if (depth_r == 7'd1) begin
              if (c.func == FN_END_OBJ && (!object_r || !expect_r)) err_nxt = 1'b1;
              completed_nxt = 1'b1;
            end
            depth_nxt = depth_r - 7'd1;
          end
        end
        default: ;
      endcase
      if (err_nxt) taken = 1'b0;
    end

    res_in.keep_going     = !err_nxt;
    res_in.selector_taken = taken;
    res_in.envelope_valid = !err_nxt && started_nxt && object_nxt && completed_nxt &&
                            (depth_nxt == '0) && has_sel_nxt &&
                            (seen_nxt[2] != seen_nxt[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      cnt_r       <= '0;
      key_r       <= KEY_OTHER;
      started_r   <= 1'b0;
      object_r    <= 1'b0;
      completed_r <= 1'b0;
      expect_r    <= 1'b0;
      has_sel_r   <= 1'b0;
      err_r       <= 1'b0;
      seen_r      <= '0;
    end else if (fire) begin
      depth_r     <= depth_nxt;
      cnt_r       <= cnt_nxt;
      key_r       <= key_nxt;
      started_r   <= started_nxt;
      object_r    <= object_nxt;
      completed_r <= completed_nxt;
      expect_r    <= expect_nxt;
      has_sel_r   <= has_sel_nxt;
      err_r       <= err_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      rq_wr_r  <= rq_wr_r + ResPtrW'(fire);
      rq_rd_r  <= rq_rd_r + ResPtrW'(rq_pop);
      rq_cnt_r <= rq_cnt_r + (ResPtrW+1)'(fire) - (ResPtrW+1)'(rq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) rq_r[rq_wr_r] <= res_in;
  end

  assign empty = (rq_cnt_r == '0);
  assign res   = rq_r[rq_rd_r];

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for json_envelope_event_checker_unit, with an envelope
// scoreboard class that predicts every result and plain tasks that drive the ports
// depends on jeec_pkg and the checker rtl
`timescale 1ns / 1ps

module tb_top;
  import jeec_pkg::*;

  localparam int TargetEvents = 1300;
  localparam int PhaseCount   = 6;
  localparam int StallLimit   = 5000;
  localparam int DrainCycles  = 6;

  typedef struct {
    func_t       func;
    logic [15:0] len;
    logic [63:0] head;
    logic        nul;
    logic        one;
  } parse_event_t;

  class envelope_scoreboard;
    localparam int MaxPrinted = 100;

    logic [6:0]  lim_depth;
    logic [5:0]  lim_members;
    logic [15:0] lim_id_len;
    logic [15:0] lim_sel_len;

    logic [6:0] depth;
    logic [5:0] members;
    key_t       cur_key;
    logic [4:0] seen;
    bit         started, is_obj, closed, want_key, has_sel, failed;

    res_t expected_q[$];
    int   mismatches;
    int   results_checked;
    int   envelopes_ok;
    int   selectors;
    int   rejected;

    function new();
      lim_depth   = RstMaxDepth;
      lim_members = RstMaxMembers;
      lim_id_len  = RstMaxIdLen;
      lim_sel_len = RstMaxSelLen;
      clear_state();
    endfunction

    function void clear_state();
      depth    = '0;
      members  = '0;
      cur_key  = KEY_OTHER;
      seen     = '0;
      started  = 1'b0;
      is_obj   = 1'b0;
      closed   = 1'b0;
      want_key = 1'b0;
      has_sel  = 1'b0;
      failed   = 1'b0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_MAX_DEPTH:   lim_depth   = v[6:0];
        REG_MAX_MEMBERS: lim_members = v[5:0];
        REG_MAX_ID_LEN:  lim_id_len  = v;
        REG_MAX_SEL_LEN: lim_sel_len = v;
        default: ;
      endcase
    endfunction

    // only the first len bytes of the head take part
    function key_t classify_key(logic [15:0] len, logic [63:0] head);
      logic [63:0] h;
      if (len == 0 || len > 7) return KEY_OTHER;
      h = head & ((64'd1 << (8 * len)) - 64'd1);
      if (len == 7 && h == 64'(WordVersion)) return KEY_VERSION;
      if (len == 2 && h == 64'(WordId)) return KEY_ID;
      if (len == 4 && h == 64'(WordType)) return KEY_TYPE;
      if (len == 6 && h == 64'(WordAction)) return KEY_ACTION;
      if (len == 7 && h == 64'(WordPayload)) return KEY_PAYLOAD;
      return KEY_OTHER;
    endfunction

    function void end_value();
      want_key = 1'b1;
      cur_key  = KEY_OTHER;
    endfunction

    // non-string value sitting directly in the root object
    function void take_root_value(bit is_int, logic is_one);
      bit ok;
      if (!is_obj || want_key) begin
        failed = 1'b1;
        return;
      end
      if (is_int && cur_key == KEY_VERSION) ok = is_one;
      else ok = !(cur_key == KEY_VERSION || cur_key == KEY_ID ||
                  cur_key == KEY_TYPE || cur_key == KEY_ACTION);
      end_value();
      if (!ok) failed = 1'b1;
    endfunction

    function void open_level();
      if (depth < DepthSat) depth++;
      if (depth > lim_depth) failed = 1'b1;
    endfunction

    function void note_event(parse_event_t e);
      res_t r;
      bit   taken;
      bit   ok;
      key_t k;
      taken = 1'b0;
      if (e.func == FN_BEGIN) begin
        clear_state();
      end else if (!failed) begin
        case (e.func)
          FN_SCALAR, FN_INTEGER: begin
            if (depth == 1) take_root_value(e.func == FN_INTEGER, e.one);
          end
          FN_STRING: begin
            if (depth == 1 && is_obj) begin
              if (want_key) begin
                if (members < MemberSat) members++;
                if (members > lim_members) failed = 1'b1;
                k = classify_key(e.len, e.head);
                cur_key  = k;
                want_key = 1'b0;
                if (k != KEY_OTHER) begin
                  if (seen[int'(k) - 1]) failed = 1'b1;
                  seen[int'(k) - 1] = 1'b1;
                end
              end else begin
                ok = 1'b1;
                case (cur_key)
                  KEY_ID: ok = (e.len <= lim_id_len) && !e.nul;
                  KEY_TYPE, KEY_ACTION: begin
                    ok = (e.len != 0) && (e.len <= lim_sel_len) && !e.nul;
                    if (ok) begin
                      has_sel = 1'b1;
                      taken   = 1'b1;
                    end
                  end
                  KEY_VERSION: ok = 1'b0;
                  default: ;
                endcase
                end_value();
                if (!ok) failed = 1'b1;
              end
            end
          end
          FN_START_OBJ: begin
            if (depth == 0) begin
              if (started) failed = 1'b1;
              started  = 1'b1;
              is_obj   = 1'b1;
              want_key = 1'b1;
              depth    = 7'd1;
            end else begin
              if (depth == 1) take_root_value(1'b0, 1'b0);
              open_level();
            end
          end
          FN_START_ARR: begin
            if (depth == 0) begin
              started = 1'b1;
              is_obj  = 1'b0;
              failed  = 1'b1;
            end else if (depth == 1) begin
              take_root_value(1'b0, 1'b0);
            end
            open_level();
          end
          FN_END_OBJ, FN_END_ARR: begin
            if (depth == 0) begin
              failed = 1'b1;
            end else begin
              if (depth == 1) begin
                if (e.func == FN_END_OBJ && (!is_obj || !want_key)) failed = 1'b1;
                closed = 1'b1;
              end
              depth--;
            end
          end
          default: ;
        endcase
        if (failed) taken = 1'b0;
      end
      r.keep_going     = !failed;
      r.envelope_valid = !failed && started && is_obj && closed && depth == 0 && has_sel &&
                         (seen[int'(KEY_TYPE) - 1] != seen[int'(KEY_ACTION) - 1]);
      r.selector_taken = taken;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report("result transaction with nothing outstanding");
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (want.envelope_valid) envelopes_ok++;
      if (want.selector_taken) selectors++;
      if (!want.keep_going) rejected++;
      if (got.keep_going !== want.keep_going)
        report($sformatf("result %0d keep_going %b, expected %b",
                         results_checked, got.keep_going, want.keep_going));
      if (got.envelope_valid !== want.envelope_valid)
        report($sformatf("result %0d envelope_valid %b, expected %b",
                         results_checked, got.envelope_valid, want.envelope_valid));
      if (got.selector_taken !== want.selector_taken)
        report($sformatf("result %0d selector_taken %b, expected %b",
                         results_checked, got.selector_taken, want.selector_taken));
    endtask
  endclass

  logic        clk;
  logic        rst_n              = 1'b0;
  logic        in_push            = 1'b0;
  logic        in_full;
  logic [2:0]  in_func            = FN_BEGIN;
  logic [15:0] in_string_len      = '0;
  logic [63:0] in_string_head     = '0;
  logic        in_string_has_nul  = 1'b0;
  logic        in_value_is_one    = 1'b0;
  logic        out_empty;
  logic        out_pop            = 1'b0;
  logic        out_keep_going;
  logic        out_envelope_valid;
  logic        out_selector_taken;
  logic        cfg_wr_en          = 1'b0;
  logic [1:0]  cfg_index          = REG_MAX_DEPTH;
  logic [15:0] cfg_wdata          = '0;

  envelope_scoreboard sb = new();
  parse_event_t       pending_seq[$];
  bit                 gaps_on = 1'b1;
  int                 events_sent = 0;
  int                 stall_cycles = 0;

  json_envelope_event_checker_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_string_len      (in_string_len),
    .in_string_head     (in_string_head),
    .in_string_has_nul  (in_string_has_nul),
    .in_value_is_one    (in_value_is_one),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_keep_going     (out_keep_going),
    .out_envelope_valid (out_envelope_valid),
    .out_selector_taken (out_selector_taken),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check on each pop transaction, then pick the next pop
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.keep_going     = out_keep_going;
      got.envelope_valid = out_envelope_valid;
      got.selector_taken = out_selector_taken;
      sb.check_result(got);
    end
    out_pop <= !gaps_on || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("[%0t] no transaction for %0d cycles", $time, StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly 1 to min(limit, 24), else zero, limit, limit+1, the top value or random
  function automatic logic [15:0] pick_len(logic [15:0] limit);
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return limit;
      2: return (limit == 16'hFFFF) ? limit : limit + 16'd1;
      3: return 16'($urandom);
      4: return 16'hFFFF;
      default: return (limit == 0) ? 16'd0 : 16'($urandom_range(1, (limit < 24) ? limit : 24));
    endcase
  endfunction

  task automatic add_event(func_t f, logic [15:0] len, logic [63:0] head, logic nul,
                           logic one);
    parse_event_t e;
    e.func = f;
    e.len  = len;
    e.head = head;
    e.nul  = nul;
    e.one  = one;
    pending_seq.push_back(e);
  endtask

  task automatic add_plain(func_t f);
    add_event(f, 16'($urandom), rand_word(), 1'($urandom), 1'($urandom));
  endtask

  task automatic add_string(logic [15:0] len, logic nul);
    add_event(FN_STRING, len, rand_word(), nul, 1'($urandom));
  endtask

  task automatic add_key(key_t k);
    logic [15:0] len;
    logic [63:0] word;
    case (k)
      KEY_VERSION: begin len = 16'd7; word = 64'(WordVersion); end
      KEY_ID:      begin len = 16'd2; word = 64'(WordId);      end
      KEY_TYPE:    begin len = 16'd4; word = 64'(WordType);    end
      KEY_ACTION:  begin len = 16'd6; word = 64'(WordAction);  end
      KEY_PAYLOAD: begin len = 16'd7; word = 64'(WordPayload); end
      default:     begin len = 16'($urandom_range(0, 12)); word = rand_word(); end
    endcase
    // junk past the key length must not change the classification
    if (len < 8 && $urandom_range(0, 1)) word |= rand_word() & ~((64'd1 << (8 * len)) - 64'd1);
    if (k != KEY_OTHER && $urandom_range(0, 24) == 0) begin
      if ($urandom_range(0, 1)) word ^= 64'd1 << $urandom_range(0, 8 * len - 1);
      else len = len + 16'd1;
    end
    add_event(FN_STRING, len, word, 1'b0, 1'($urandom));
  endtask

  task automatic add_value(int levels);
    int n;
    n = $urandom_range(0, 3);
    case ($urandom_range(0, (levels > 0) ? 5 : 2))
      0: add_plain(FN_SCALAR);
      1: add_plain(FN_INTEGER);
      2: add_string(pick_len(16'd40), $urandom_range(0, 9) == 0);
      3, 4: begin
        add_plain(FN_START_OBJ);
        repeat (n) begin
          add_string(pick_len(16'd12), 1'b0);
          add_value(levels - 1);
        end
        add_plain(FN_END_OBJ);
      end
      default: begin
        add_plain(FN_START_ARR);
        repeat (n) add_value(levels - 1);
        add_plain(FN_END_ARR);
      end
    endcase
  endtask

  // straight run of opens to the depth limit or one past it
  task automatic add_deep_chain();
    func_t closers[$];
    int    n;
    n = int'(sb.lim_depth) - 1 + int'($urandom_range(0, 1));
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        add_plain(FN_START_OBJ);
        closers.push_front(FN_END_OBJ);
      end else begin
        add_plain(FN_START_ARR);
        closers.push_front(FN_END_ARR);
      end
    end
    add_plain(FN_SCALAR);
    foreach (closers[i]) add_plain(closers[i]);
  endtask

  task automatic add_member_value(key_t k);
    case (k)
      KEY_VERSION: begin
        if ($urandom_range(0, 9) != 0)
          add_event(FN_INTEGER, 16'($urandom), rand_word(), 1'($urandom),
                    $urandom_range(0, 9) != 0);
        else add_value(1);
      end
      KEY_ID: add_string(pick_len(sb.lim_id_len), $urandom_range(0, 19) == 0);
      KEY_TYPE, KEY_ACTION: begin
        if ($urandom_range(0, 9) != 0)
          add_string(pick_len(sb.lim_sel_len), $urandom_range(0, 19) == 0);
        else add_value(1);
      end
      default: begin
        if ($urandom_range(0, 29) == 0 && (sb.lim_depth < 20 || $urandom_range(0, 3) == 0))
          add_deep_chain();
        else add_value(2);
      end
    endcase
  endtask

  task automatic build_envelope();
    key_t order[$];
    key_t tmp;
    int   pick;
    int   extra;
    int   j;
    add_plain(FN_BEGIN);
    if ($urandom_range(0, 19) == 0) add_value(0);
    add_plain(FN_START_OBJ);
    if ($urandom_range(0, 9) != 0) order.push_back(KEY_VERSION);
    if ($urandom_range(0, 9) != 0) order.push_back(KEY_ID);
    pick = $urandom_range(0, 19);
    if (pick < 9) order.push_back(KEY_TYPE);
    else if (pick < 18) order.push_back(KEY_ACTION);
    else if (pick == 18) begin
      order.push_back(KEY_TYPE);
      order.push_back(KEY_ACTION);
    end
    if ($urandom_range(0, 9) < 7) order.push_back(KEY_PAYLOAD);
    // now and then fill the root object up to the member limit or just past it
    if ($urandom_range(0, 19) == 0)
      extra = int'(sb.lim_members) - order.size() + int'($urandom_range(0, 1));
    else extra = $urandom_range(0, 2);
    if (extra < 0) extra = 0;
    repeat (extra) order.push_back(KEY_OTHER);
    if ($urandom_range(0, 24) == 0 && order.size() > 0)
      order.push_back(order[$urandom_range(0, order.size() - 1)]);
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      add_key(order[i]);
      add_member_value(order[i]);
    end
    add_plain(FN_END_OBJ);
    if ($urandom_range(0, 19) == 0) add_value(1);
    if ($urandom_range(0, 11) == 0) begin
      j = $urandom_range(1, pending_seq.size() - 1);
      pending_seq[j].func = func_t'($urandom_range(0, 7));
    end
  endtask

  task automatic build_noise();
    if ($urandom_range(0, 1)) add_plain(FN_BEGIN);
    repeat ($urandom_range(3, 12)) add_plain(func_t'($urandom_range(0, 7)));
  endtask

  task automatic build_directed();
    // close with nothing open
    add_plain(FN_BEGIN);
    add_plain(FN_END_OBJ);
    // array as the root
    add_plain(FN_BEGIN);
    add_plain(FN_START_ARR);
    add_plain(FN_SCALAR);
    // string before the root is ignored, then an integer where a key belongs
    add_plain(FN_BEGIN);
    add_event(FN_STRING, 16'd0, 64'd0, 1'b0, 1'b0);
    add_plain(FN_START_OBJ);
    add_event(FN_INTEGER, 16'd0, 64'd0, 1'b0, 1'b1);
    // complete envelope at the default limits, then a second root object
    add_plain(FN_BEGIN);
    add_plain(FN_START_OBJ);
    add_event(FN_STRING, 16'd7, 64'(WordVersion), 1'b0, 1'b0);
    add_event(FN_INTEGER, 16'hFFFF, '1, 1'b1, 1'b1);
    add_event(FN_STRING, 16'd2, 64'(WordId), 1'b0, 1'b0);
    add_event(FN_STRING, RstMaxIdLen, '1, 1'b0, 1'b1);
    add_event(FN_STRING, 16'd4, 64'(WordType), 1'b0, 1'b0);
    add_event(FN_STRING, RstMaxSelLen, 64'd0, 1'b0, 1'b0);
    add_event(FN_STRING, 16'd7, 64'(WordPayload), 1'b0, 1'b0);
    add_plain(FN_START_OBJ);
    add_event(FN_STRING, 16'hFFFF, '1, 1'b1, 1'b1);
    add_plain(FN_SCALAR);
    add_plain(FN_END_OBJ);
    add_plain(FN_END_OBJ);
    add_plain(FN_START_OBJ);
  endtask

  task automatic send_event(parse_event_t e);
    while (gaps_on && $urandom_range(0, 99) < 24) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push           <= 1'b1;
    in_func           <= e.func;
    in_string_len     <= e.len;
    in_string_head    <= e.head;
    in_string_has_nul <= e.nul;
    in_value_is_one   <= e.one;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_event(e);
    events_sent++;
  endtask

  task automatic flush_sequence();
    foreach (pending_seq[i]) send_event(pending_seq[i]);
    pending_seq.delete();
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(logic [6:0] d, logic [5:0] m, logic [15:0] id_len,
                                logic [15:0] sel_len);
    write_reg(REG_MAX_DEPTH, 16'(d));
    write_reg(REG_MAX_MEMBERS, 16'(m));
    write_reg(REG_MAX_ID_LEN, id_len);
    write_reg(REG_MAX_SEL_LEN, sel_len);
    cfg_wr_en <= 1'b0;
  endtask

  // no input transaction pending; wait out every outstanding result and the pipeline
  task automatic drain();
    in_push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    build_directed();
    flush_sequence();
    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: apply_settings(7'd1, 6'd1, 16'd0, 16'd1);
          2: apply_settings(7'd126, 6'd62, 16'hFFFF, 16'hFFFF);
          3: apply_settings(7'($urandom_range(1, 126)), 6'($urandom_range(1, 62)),
                            16'($urandom), 16'($urandom_range(1, 65535)));
          4: apply_settings(7'd4, 6'd6, 16'd16, 16'd8);
          default: apply_settings(RstMaxDepth, RstMaxMembers, RstMaxIdLen, RstMaxSelLen);
        endcase
        @(posedge clk);
      end
      // one whole setting runs back to back on both sides
      gaps_on = (phase != 3);
      while (events_sent < TargetEvents * (phase + 1) / PhaseCount) begin
        if ($urandom_range(0, 4) == 0) build_noise();
        else build_envelope();
        flush_sequence();
      end
    end
    drain();
    $display("covered %0d parse events over %0d register settings, with and without gaps",
             events_sent, PhaseCount);
    $display("%0d results checked: %0d complete envelope, %0d selector taken, %0d rejected",
             sb.results_checked, sb.envelopes_ok, sb.selectors, sb.rejected);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches,
               sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
